FILE: src/mnwt_pkg.sv
package mnwt_pkg;

    // fixed field widths
    localparam int NODE_INDEX_W = 10;
    localparam int DIST_W       = 16;
    localparam int SQ_W         = 2 * DIST_W;
    localparam int SUM_W        = SQ_W + 2;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic setup;
        logic scan;
        logic commit;
    } mnwt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic scan_done;
    } mnwt_status_t;

endpackage

FILE: src/mnwt_ram.sv
module mnwt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/mnwt_ctrl.sv
module mnwt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  mnwt_pkg::mnwt_status_t status,
    output mnwt_pkg::mnwt_cmd_t    cmd
);

    import mnwt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.hit || status.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid follows commit and the receiver
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: src/mnwt_dp.sv
module mnwt_dp #(
    parameter int MAX_NODES   = 1024,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mnwt_pkg::mnwt_cmd_t                    cmd,
    output mnwt_pkg::mnwt_status_t                 status,
    input  logic                                   merge_enable,
    input  logic [mnwt_pkg::DIST_W-1:0]            min_distance,
    input  logic signed [COORD_WIDTH-1:0]          coord_x,
    input  logic signed [COORD_WIDTH-1:0]          coord_y,
    input  logic signed [COORD_WIDTH-1:0]          coord_z,
    input  logic                                   first_of_submesh,
    output logic [mnwt_pkg::NODE_INDEX_W-1:0]      node_index,
    output logic                                   was_merged,
    output logic                                   overflow
);

    import mnwt_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int MAG_W = COORD_WIDTH + 1;
    localparam int CMP_W = (MAG_W > DIST_W) ? MAG_W : DIST_W;
    localparam int WORD_W = 3 * COORD_WIDTH;

    // captured item
    logic signed [COORD_WIDTH-1:0] coord_reg [3];
    logic                          first_reg;

    // table state
    logic [CNT_W-1:0] node_count_reg;
    logic             merging_active_reg;
    logic [CNT_W-1:0] scan_addr_reg;
    logic             found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [SQ_W-1:0]  dsq_reg;

    // compare pipeline
    logic             v0_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic [IDX_W-1:0] idx0_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic             close1_reg;
    logic             close2_reg;
    logic [DIST_W-1:0] mag1_reg [3];
    logic [SQ_W-1:0]   sq2_reg [3];

    // result registers
    logic [NODE_INDEX_W-1:0] node_index_reg;
    logic                    was_merged_reg;
    logic                    overflow_reg;

    logic                          issue;
    logic                          full;
    logic                          append;
    logic [WORD_W-1:0]             rd_word;
    logic signed [COORD_WIDTH-1:0] node_c [3];
    logic signed [COORD_WIDTH:0]   diff [3];
    logic [MAG_W-1:0]              mag [3];
    logic [DIST_W-1:0]             mag_n [3];
    logic [2:0]                    close_a;
    logic [SUM_W-1:0]              sum;
    logic                          below;

    assign issue  = cmd.scan && merging_active_reg && (scan_addr_reg != node_count_reg);
    assign full   = (node_count_reg == CNT_W'(MAX_NODES));
    assign append = cmd.commit && !found_reg && !full;

    // node store
    mnwt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_NODES)
    ) u_store (
        .clk   (clk),
        .we    (append),
        .waddr (node_count_reg[IDX_W-1:0]),
        .wdata ({coord_reg[2], coord_reg[1], coord_reg[0]}),
        .re    (issue),
        .raddr (scan_addr_reg[IDX_W-1:0]),
        .rdata (rd_word)
    );

    // per-axis difference magnitude and early reject
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            node_c[k] = rd_word[k*COORD_WIDTH +: COORD_WIDTH];
            diff[k]   = $signed({node_c[k][COORD_WIDTH-1], node_c[k]})
                      - $signed({coord_reg[k][COORD_WIDTH-1], coord_reg[k]});
            mag[k]    = diff[k][COORD_WIDTH] ? $unsigned(-diff[k]) : $unsigned(diff[k]);
            close_a[k] = CMP_W'(mag[k]) < CMP_W'(min_distance);
            mag_n[k]  = DIST_W'(mag[k]);
        end
    end

    // sum of squares against the squared threshold
    assign sum   = SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1]) + SUM_W'(sq2_reg[2]);
    assign below = sum < SUM_W'(dsq_reg);

    assign status.hit       = cmd.scan && v2_reg && close2_reg && below;
    assign status.scan_done = (!merging_active_reg || (scan_addr_reg == node_count_reg))
                            && !v0_reg && !v1_reg && !v2_reg;

    // pipeline payload, no reset
    always_ff @(posedge clk)
    begin
        dsq_reg <= SQ_W'(min_distance) * SQ_W'(min_distance);
        if (cmd.capture)
        begin
            coord_reg[0] <= coord_x;
            coord_reg[1] <= coord_y;
            coord_reg[2] <= coord_z;
            first_reg    <= first_of_submesh;
        end
        if (cmd.scan)
        begin
            idx0_reg   <= scan_addr_reg[IDX_W-1:0];
            idx1_reg   <= idx0_reg;
            idx2_reg   <= idx1_reg;
            close1_reg <= &close_a;
            close2_reg <= close1_reg;
            for (int k = 0; k < 3; k++)
            begin
                mag1_reg[k] <= mag_n[k];
                sq2_reg[k]  <= SQ_W'(mag1_reg[k]) * SQ_W'(mag1_reg[k]);
            end
        end
        if (status.hit)
        begin
            match_idx_reg <= idx2_reg;
        end
        if (cmd.commit)
        begin
            if (found_reg)
            begin
                node_index_reg <= NODE_INDEX_W'(match_idx_reg);
                was_merged_reg <= 1'b1;
                overflow_reg   <= 1'b0;
            end
            else if (full)
            begin
                node_index_reg <= '0;
                was_merged_reg <= 1'b0;
                overflow_reg   <= 1'b1;
            end
            else
            begin
                node_index_reg <= NODE_INDEX_W'(node_count_reg);
                was_merged_reg <= 1'b0;
                overflow_reg   <= 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg     <= '0;
            merging_active_reg <= 1'b0;
            scan_addr_reg      <= '0;
            found_reg          <= 1'b0;
            v0_reg             <= 1'b0;
            v1_reg             <= 1'b0;
            v2_reg             <= 1'b0;
        end
        else
        begin
            if (cmd.setup)
            begin
                if (first_reg)
                begin
                    merging_active_reg <= merge_enable && (node_count_reg != '0);
                end
                scan_addr_reg <= '0;
                found_reg     <= 1'b0;
                v0_reg        <= 1'b0;
                v1_reg        <= 1'b0;
                v2_reg        <= 1'b0;
            end
            else if (cmd.scan)
            begin
                v0_reg <= issue;
                v1_reg <= v0_reg;
                v2_reg <= v1_reg;
                if (issue)
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                if (status.hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (append)
            begin
                node_count_reg <= node_count_reg + 1'b1;
            end
        end
    end

    assign node_index = node_index_reg;
    assign was_merged = was_merged_reg;
    assign overflow   = overflow_reg;

endmodule

FILE: src/mesh_node_weld_table.sv
// Vertex-welding node table.
// Input channel (in_valid/in_ready) takes one node per transaction: coord_x/y/z and
// first_of_submesh. Output channel (out_valid/out_ready) returns one transaction per
// node: node_index, was_merged, overflow.
// A sub-mesh start turns merging on for that sub-mesh when merge_enable is set and the
// table is not empty. While merging, stored nodes are read from the node RAM one per
// cycle in index order through a 3-stage distance compare; the first node strictly
// inside min_distance is returned. Otherwise the node is appended, or overflow is
// flagged when the table is full.
// When merging, the time from input to result grows with the number of stored nodes
// and is shorter on an early match; the node RAM read port gives one entry per cycle.
// One node is processed at a time.
// The output register lets the next node be accepted while a result waits; a stalled
// receiver holds the following node before its commit.
// Reset clears the node count, merging state and configuration registers; the node RAM
// needs no clearing pass since only written entries are read. Registers via APB:
// merge_enable at 0x0, min_distance at 0x4.
module mesh_node_weld_table #(
    parameter int MAX_NODES   = 1024,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COORD_WIDTH-1:0]         coord_x,
    input  logic signed [COORD_WIDTH-1:0]         coord_y,
    input  logic signed [COORD_WIDTH-1:0]         coord_z,
    input  logic                                  first_of_submesh,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [mnwt_pkg::NODE_INDEX_W-1:0]     node_index,
    output logic                                  was_merged,
    output logic                                  overflow,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mnwt_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [mnwt_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [mnwt_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    import mnwt_pkg::*;

    localparam logic REG_MERGE_ENABLE = 1'b0;
    localparam logic REG_MIN_DISTANCE = 1'b1;

    logic              merge_enable_reg;
    logic [DIST_W-1:0] min_distance_reg;
    logic              reg_sel;
    logic              cfg_write;
    mnwt_cmd_t         cmd;
    mnwt_status_t      status;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_enable_reg <= 1'b0;
            min_distance_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_MERGE_ENABLE: merge_enable_reg <= pwdata[0];
                REG_MIN_DISTANCE: min_distance_reg <= pwdata[DIST_W-1:0];
                default:          merge_enable_reg <= merge_enable_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_sel)
            REG_MERGE_ENABLE: prdata = APB_DATA_W'(merge_enable_reg);
            REG_MIN_DISTANCE: prdata = APB_DATA_W'(min_distance_reg);
            default:          prdata = '0;
        endcase
    end

    mnwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mnwt_dp #(
        .MAX_NODES   (MAX_NODES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .merge_enable     (merge_enable_reg),
        .min_distance     (min_distance_reg),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .coord_z          (coord_z),
        .first_of_submesh (first_of_submesh),
        .node_index       (node_index),
        .was_merged       (was_merged),
        .overflow         (overflow)
    );

    // a result is never both merged and dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_merged && overflow))
        else $error("merged and overflow both set");

    // no scan while a new item can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && cmd.scan))
        else $error("scan while ready for input");

    // a commit always presents a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit without result");

    // a commit never overwrites a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || out_ready))
        else $error("pending result overwritten");

endmodule
